/* hw/rtl/tsc_pkg.sv */
`timescale 1ns / 1ps

package tsc_pkg;

	typedef enum logic [1:0] {
		OP_ENCODER   = 2'd0,
		OP_BUTTON    = 2'd1,
		OP_TEMP      = 2'd2,
		OP_HOLD_DONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		LED_RED   = 2'd0,
		LED_BLUE  = 2'd1,
		LED_GREEN = 2'd2
	} led_t;

	// what the servo tracks
	typedef enum logic [1:0] {
		SRC_TEMP = 2'd0,
		SRC_LOW  = 2'd1,
		SRC_HIGH = 2'd2
	} servo_src_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT_MIN  = 3'd0,
		REG_SETPOINT_MAX  = 3'd1,
		REG_ALARM_MARGIN  = 3'd2,
		REG_SERVO_FLOOR   = 3'd3,
		REG_SERVO_CEILING = 3'd4
	} cfg_reg_t;

	localparam logic [6:0] SETPOINT_MIN_RST  = 7'd50;
	localparam logic [6:0] SETPOINT_MAX_RST  = 7'd90;
	localparam logic [3:0] ALARM_MARGIN_RST  = 4'd3;
	localparam logic [5:0] SERVO_FLOOR_RST   = 6'd12;
	localparam logic [5:0] SERVO_CEILING_RST = 6'd35;
	localparam logic [6:0] LOW_SETPOINT_RST  = 7'd50;
	localparam logic [6:0] HIGH_SETPOINT_RST = 7'd90;
	localparam logic [6:0] ADJUST_COUNT_RST  = 7'd50;
	localparam logic [1:0] QUAD_PHASE_RST    = 2'd3;

	// F tenths = floor(9*raw/8) + 320
	localparam logic [11:0] FAH_OFFSET = 12'd320;
	// whole degrees F = floor((9*raw + 2560) / 80) = floor(floor(n/16) / 5)
	localparam logic [14:0] DEG_OFFSET = 15'd2560;
	// floor(x/5) = (x*13108) >> 16, exact for x < 16384
	localparam logic [13:0] RECIP_5    = 14'd13108;
	// floor(23*x/60) = (x * 23 * 8739) >> 19, exact for 23*x < 10082
	localparam logic [17:0] SERVO_MUL  = 18'd200997;
	localparam logic signed [7:0] SERVO_BASE = 8'sd50;

	// next phase for a +1 step: 0 -> 1 -> 3 -> 2 -> 0
	function automatic logic [1:0] quad_fwd(input logic [1:0] phase);
		logic [1:0] r;
		case (phase)
			2'd0: r = 2'd1;
			2'd1: r = 2'd3;
			2'd2: r = 2'd0;
			2'd3: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] quad_bwd(input logic [1:0] phase);
		logic [1:0] r;
		case (phase)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			2'd2: r = 2'd3;
			2'd3: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/thermostat_setpoint_controller.sv */
`timescale 1ns / 1ps

// Thermostat setpoint controller.
// Input channel (in_valid/in_ready) carries one event per transaction: an
// encoder sample, a button sample, a raw temperature reading or a servo
// hold-expired tick, selected by opcode. Every input transaction yields exactly
// one result transaction on out_valid/out_ready with the temperature results
// and the current setpoints, adjust selection and encoder count.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// limit registers; cfg_ready is always high and writes to unused indexes are
// dropped. Write config only while no transaction is in flight.
// A transaction passes the input register, the temperature conversion stage and
// the result register in that order before out_valid rises.
// Throughput: one transaction per cycle; the three registers form an elastic
// pipeline, so input stays open while a result waits as long as a stage
// ahead is free. When out_ready stays low the pipeline fills and in_ready
// drops after three held transactions.
// Reset (arst_n low) empties the pipeline and restores the default limits,
// setpoints 50/90, count 50, encoder phase 3 and servo following temperature.
module thermostat_setpoint_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic                              enc_a,
	input  logic                              enc_b,
	input  logic                              low_pressed,
	input  logic                              high_pressed,
	input  logic [10:0]                       raw_temperature,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [11:0]                       fahrenheit_tenths,
	output logic [5:0]                        servo_position,
	output logic [1:0]                        led_color,
	output logic                              alarm_start,
	output logic [6:0]                        low_setpoint_out,
	output logic [6:0]                        high_setpoint_out,
	output logic                              adjusting_high,
	output logic [6:0]                        encoder_count
);
	import tsc_pkg::*;

	// ---------------- configuration registers ----------------
	logic [6:0] setpoint_min_q, setpoint_max_q;
	logic [3:0] alarm_margin_q;
	logic [5:0] servo_floor_q, servo_ceiling_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_min_q  <= SETPOINT_MIN_RST;
			setpoint_max_q  <= SETPOINT_MAX_RST;
			alarm_margin_q  <= ALARM_MARGIN_RST;
			servo_floor_q   <= SERVO_FLOOR_RST;
			servo_ceiling_q <= SERVO_CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETPOINT_MIN:  setpoint_min_q  <= cfg_data[6:0];
				REG_SETPOINT_MAX:  setpoint_max_q  <= cfg_data[6:0];
				REG_ALARM_MARGIN:  alarm_margin_q  <= cfg_data[3:0];
				REG_SERVO_FLOOR:   servo_floor_q   <= cfg_data[5:0];
				REG_SERVO_CEILING: servo_ceiling_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	logic valid_s1, valid_s2, out_valid_q;
	logic adv1, adv2;

	assign adv2     = valid_s2 && (!out_valid_q || out_ready);
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign in_ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || adv2)
				valid_s2 <= adv1;
			if (adv2)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [1:0]  opcode_s1;
	logic        enc_a_s1, enc_b_s1, low_pressed_s1, high_pressed_s1;
	logic [10:0] raw_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1       <= opcode;
			enc_a_s1        <= enc_a;
			enc_b_s1        <= enc_b;
			low_pressed_s1  <= low_pressed;
			high_pressed_s1 <= high_pressed;
			raw_s1          <= raw_temperature;
		end
	end

	// temperature conversion, no state involved
	logic [14:0] nine_raw;
	logic [14:0] deg_num;
	logic [24:0] deg_prod;
	logic [11:0] fah_c;
	logic [8:0]  deg_c;

	assign nine_raw = {1'b0, raw_s1, 3'b000} + {4'b0000, raw_s1};
	assign fah_c    = nine_raw[14:3] + FAH_OFFSET;
	assign deg_num  = nine_raw + DEG_OFFSET;
	assign deg_prod = deg_num[14:4] * RECIP_5;
	assign deg_c    = deg_prod[24:16];

	// ---------------- stage 2 ----------------
	logic [1:0]  opcode_s2;
	logic        enc_a_s2, enc_b_s2, low_pressed_s2, high_pressed_s2;
	logic [11:0] fah_s2;
	logic [8:0]  deg_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			opcode_s2       <= opcode_s1;
			enc_a_s2        <= enc_a_s1;
			enc_b_s2        <= enc_b_s1;
			low_pressed_s2  <= low_pressed_s1;
			high_pressed_s2 <= high_pressed_s1;
			fah_s2          <= fah_c;
			deg_s2          <= deg_c;
		end
	end

	// controller state
	logic [1:0]  quad_phase_q;
	logic [6:0]  adjust_count_q, low_setpoint_q, high_setpoint_q;
	logic        adjust_select_q, alarm_latched_q;
	servo_src_t  servo_source_q;

	// encoder step and clamps
	logic [1:0]        enc_target, enc_phase;
	logic signed [8:0] cnt_step, cnt_clamp, cnt_final;
	logic signed [8:0] min_s, max_s, low_s, high_s;

	assign enc_target = {enc_b_s2, enc_a_s2};
	assign min_s  = $signed({2'b00, setpoint_min_q});
	assign max_s  = $signed({2'b00, setpoint_max_q});
	assign low_s  = $signed({2'b00, low_setpoint_q});
	assign high_s = $signed({2'b00, high_setpoint_q});

	always_comb begin
		enc_phase = quad_phase_q;
		cnt_step  = $signed({2'b00, adjust_count_q});
		if (enc_target == quad_fwd(quad_phase_q)) begin
			enc_phase = enc_target;
			cnt_step  = $signed({2'b00, adjust_count_q}) + 9'sd1;
		end else if (enc_target == quad_bwd(quad_phase_q)) begin
			enc_phase = enc_target;
			cnt_step  = $signed({2'b00, adjust_count_q}) - 9'sd1;
		end
		// minimum wins when the limits cross
		if (cnt_step <= min_s)
			cnt_clamp = min_s;
		else if (cnt_step >= max_s)
			cnt_clamp = max_s;
		else
			cnt_clamp = cnt_step;
		// keep the count on its own side of the other setpoint
		cnt_final = cnt_clamp;
		if (!adjust_select_q) begin
			if (cnt_clamp >= high_s)
				cnt_final = low_s;
		end else begin
			if (cnt_clamp <= low_s)
				cnt_final = high_s;
		end
	end

	// servo position
	logic [8:0]        servo_x;
	logic [26:0]       servo_prod;
	logic signed [7:0] servo_raw, floor_s, ceil_s, servo_clamp;

	always_comb begin
		case (servo_source_q)
			SRC_LOW:  servo_x = {2'b00, low_setpoint_q};
			SRC_HIGH: servo_x = {2'b00, high_setpoint_q};
			default:  servo_x = deg_s2;
		endcase
	end

	assign servo_prod = servo_x * SERVO_MUL;
	assign servo_raw  = SERVO_BASE - $signed({1'b0, servo_prod[25:19]});
	assign floor_s    = $signed({2'b00, servo_floor_q});
	assign ceil_s     = $signed({2'b00, servo_ceiling_q});

	always_comb begin
		if (servo_raw < floor_s)
			servo_clamp = floor_s;
		else if (servo_raw > ceil_s)
			servo_clamp = ceil_s;
		else
			servo_clamp = servo_raw;
	end

	// alarm bounds in signed arithmetic, low bound may go negative
	logic signed [9:0] deg_w, alarm_hi, alarm_lo;
	logic              above_band, below_band;

	assign deg_w      = $signed({1'b0, deg_s2});
	assign alarm_hi   = $signed({3'b000, high_setpoint_q}) + $signed({6'b000000, alarm_margin_q});
	assign alarm_lo   = $signed({3'b000, low_setpoint_q}) - $signed({6'b000000, alarm_margin_q});
	assign above_band = deg_w > alarm_hi;
	assign below_band = deg_w < alarm_lo;

	// next state and result
	logic [1:0]  phase_n;
	logic [6:0]  count_n, low_n, high_n;
	logic        select_n, latched_n;
	servo_src_t  source_n;
	logic [11:0] fah_n;
	logic [5:0]  servo_n;
	led_t        led_n;
	logic        alarm_n;

	always_comb begin
		phase_n   = quad_phase_q;
		count_n   = adjust_count_q;
		select_n  = adjust_select_q;
		source_n  = servo_source_q;
		latched_n = alarm_latched_q;
		low_n     = low_setpoint_q;
		high_n    = high_setpoint_q;
		fah_n     = '0;
		servo_n   = '0;
		led_n     = LED_RED;
		alarm_n   = 1'b0;
		case (opcode_s2)
			OP_ENCODER: begin
				phase_n = enc_phase;
				count_n = cnt_final[6:0];
			end
			OP_BUTTON: begin
				// high button overrides when both are pressed
				if (low_pressed_s2) begin
					select_n = 1'b0;
					count_n  = low_setpoint_q;
					source_n = SRC_LOW;
				end
				if (high_pressed_s2) begin
					select_n = 1'b1;
					count_n  = high_setpoint_q;
					source_n = SRC_HIGH;
				end
			end
			OP_TEMP: begin
				fah_n   = fah_s2;
				servo_n = servo_clamp[5:0];
				if (deg_s2 < {2'b00, low_setpoint_q})
					led_n = LED_RED;
				else if (deg_s2 > {2'b00, high_setpoint_q})
					led_n = LED_BLUE;
				else
					led_n = LED_GREEN;
				if (!alarm_latched_q && (above_band || below_band)) begin
					alarm_n   = 1'b1;
					latched_n = 1'b1;
				end else if (!above_band && !below_band) begin
					latched_n = 1'b0;
				end
			end
			OP_HOLD_DONE: begin
				source_n = SRC_TEMP;
			end
			default: ;
		endcase
		if (!select_n) begin
			if (low_setpoint_q < high_setpoint_q)
				low_n = count_n;
		end else begin
			if (high_setpoint_q > low_setpoint_q)
				high_n = count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_phase_q    <= QUAD_PHASE_RST;
			adjust_count_q  <= ADJUST_COUNT_RST;
			low_setpoint_q  <= LOW_SETPOINT_RST;
			high_setpoint_q <= HIGH_SETPOINT_RST;
			adjust_select_q <= 1'b0;
			servo_source_q  <= SRC_TEMP;
			alarm_latched_q <= 1'b0;
		end else if (adv2) begin
			quad_phase_q    <= phase_n;
			adjust_count_q  <= count_n;
			low_setpoint_q  <= low_n;
			high_setpoint_q <= high_n;
			adjust_select_q <= select_n;
			servo_source_q  <= source_n;
			alarm_latched_q <= latched_n;
		end
	end

	// ---------------- result register ----------------
	logic [11:0] fahrenheit_tenths_q;
	logic [5:0]  servo_position_q;
	logic [1:0]  led_color_q;
	logic        alarm_start_q;

	always_ff @(posedge clk) begin
		if (adv2) begin
			fahrenheit_tenths_q <= fah_n;
			servo_position_q    <= servo_n;
			led_color_q         <= led_n;
			alarm_start_q       <= alarm_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign fahrenheit_tenths = fahrenheit_tenths_q;
	assign servo_position    = servo_position_q;
	assign led_color         = led_color_q;
	assign alarm_start       = alarm_start_q;
	// setpoint fields follow the state, which only moves with the result register
	assign low_setpoint_out  = low_setpoint_q;
	assign high_setpoint_out = high_setpoint_q;
	assign adjusting_high    = adjust_select_q;
	assign encoder_count     = adjust_count_q;

	// ---------------- assertions ----------------
	a_alarm_not_green: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm_start |-> led_color != LED_GREEN)
		else $error("alarm fired on an in-band reading");

	a_alarm_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && alarm_latched_q |=> !alarm_start)
		else $error("alarm fired while latched");

	a_servo_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && opcode_s2 == OP_TEMP && servo_floor_q <= servo_ceiling_q
		|=> servo_position >= servo_floor_q && servo_position <= servo_ceiling_q)
		else $error("servo position outside floor and ceiling");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && out_valid_q && !out_ready)
		else $error("input blocked while the pipeline has room");

endmodule

/* tb/thermostat_checker.sv */
`timescale 1ns / 1ps

module thermostat_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic                           enc_a,
	input  logic                           enc_b,
	input  logic                           low_pressed,
	input  logic                           high_pressed,
	input  logic [10:0]                    raw_temperature,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [11:0]                    fahrenheit_tenths,
	input  logic [5:0]                     servo_position,
	input  logic [1:0]                     led_color,
	input  logic                           alarm_start,
	input  logic [6:0]                     low_setpoint_out,
	input  logic [6:0]                     high_setpoint_out,
	input  logic                           adjusting_high,
	input  logic [6:0]                     encoder_count,
	output int                             mismatches,
	output int                             pending
);
	import tsc_pkg::*;

	typedef struct packed {
		logic [11:0] fah_tenths;
		logic [5:0]  servo;
		led_t        led;
		logic        alarm;
		logic [6:0]  low_sp;
		logic [6:0]  high_sp;
		logic        adj_high;
		logic [6:0]  count;
	} status_t;

	status_t status_q[$];
	status_t want;

	// limit registers
	logic [6:0] sp_min, sp_max;
	logic [3:0] margin;
	logic [5:0] servo_lo, servo_hi;

	// controller state
	logic [1:0]  phase;
	logic [6:0]  count, low_sp, high_sp;
	logic        adj_high;
	servo_src_t  src;
	logic        alarm_latched;

	// position of a phase along the up-counting rotation 0,1,3,2
	function automatic int ring_pos(logic [1:0] p);
		case (p)
			2'd0: return 0;
			2'd1: return 1;
			2'd3: return 2;
			default: return 3;
		endcase
	endfunction

	function automatic logic [5:0] servo_target(int x);
		int v, fl, cl;
		fl = servo_lo;
		cl = servo_hi;
		v = 50 - (23 * x) / 60;
		// floor checked first, so an inverted pair favors the floor
		if (v < fl)
			v = fl;
		else if (v > cl)
			v = cl;
		return v[5:0];
	endfunction

	function automatic status_t next_status(logic [1:0] op, logic a, logic b, logic lp,
			logic hp, logic [10:0] raw);
		status_t res;
		logic [1:0] tgt;
		int cnt, lo, hi, m, raw_i, fah, deg;
		res = '0;
		case (opcode_t'(op))
			OP_ENCODER: begin
				tgt = {b, a};
				cnt = count;
				if (ring_pos(tgt) == (ring_pos(phase) + 1) % 4) begin
					phase = tgt;
					cnt++;
				end else if (ring_pos(tgt) == (ring_pos(phase) + 3) % 4) begin
					phase = tgt;
					cnt--;
				end
				lo = sp_min;
				hi = sp_max;
				if (cnt <= lo)
					cnt = lo;
				else if (cnt >= hi)
					cnt = hi;
				// count must not cross the other setpoint
				lo = low_sp;
				hi = high_sp;
				if (!adj_high) begin
					if (cnt >= hi)
						cnt = lo;
				end else if (cnt <= lo) begin
					cnt = hi;
				end
				count = cnt[6:0];
			end
			OP_BUTTON: begin
				if (lp) begin
					adj_high = 1'b0;
					count = low_sp;
					src = SRC_LOW;
				end
				if (hp) begin
					adj_high = 1'b1;
					count = high_sp;
					src = SRC_HIGH;
				end
			end
			OP_TEMP: begin
				raw_i = raw;
				fah = (raw_i * 90 / 16) / 5 + 320;
				deg = fah / 10;
				case (src)
					SRC_LOW: res.servo = servo_target(low_sp);
					SRC_HIGH: res.servo = servo_target(high_sp);
					default: res.servo = servo_target(deg);
				endcase
				lo = low_sp;
				hi = high_sp;
				m = margin;
				if (deg < lo)
					res.led = LED_RED;
				else if (deg > hi)
					res.led = LED_BLUE;
				else
					res.led = LED_GREEN;
				if (!alarm_latched && (deg > hi + m || deg < lo - m)) begin
					res.alarm = 1'b1;
					alarm_latched = 1'b1;
				end
				if (deg <= hi + m && deg >= lo - m)
					alarm_latched = 1'b0;
				res.fah_tenths = fah[11:0];
			end
			OP_HOLD_DONE: src = SRC_TEMP;
			default: ;
		endcase
		if (!adj_high) begin
			if (low_sp < high_sp)
				low_sp = count;
		end else if (high_sp > low_sp) begin
			high_sp = count;
		end
		res.low_sp = low_sp;
		res.high_sp = high_sp;
		res.adj_high = adj_high;
		res.count = count;
		return res;
	endfunction

	task automatic check_field(string field, int want_v, int got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_min = SETPOINT_MIN_RST;
			sp_max = SETPOINT_MAX_RST;
			margin = ALARM_MARGIN_RST;
			servo_lo = SERVO_FLOOR_RST;
			servo_hi = SERVO_CEILING_RST;
			phase = QUAD_PHASE_RST;
			count = ADJUST_COUNT_RST;
			low_sp = LOW_SETPOINT_RST;
			high_sp = HIGH_SETPOINT_RST;
			adj_high = 1'b0;
			src = SRC_TEMP;
			alarm_latched = 1'b0;
			status_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SETPOINT_MIN: sp_min = cfg_data;
					REG_SETPOINT_MAX: sp_max = cfg_data;
					REG_ALARM_MARGIN: margin = cfg_data[3:0];
					REG_SERVO_FLOOR: servo_lo = cfg_data[5:0];
					REG_SERVO_CEILING: servo_hi = cfg_data[5:0];
					default: ;
				endcase
			end
			// output transaction belongs to an older input, so check before queueing
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, expected nothing, actual count %0d",
						$time, encoder_count);
				end else begin
					want = status_q.pop_front();
					check_field("fahrenheit_tenths", want.fah_tenths, fahrenheit_tenths);
					check_field("servo_position", want.servo, servo_position);
					check_field("led_color", want.led, led_color);
					check_field("alarm_start", want.alarm, alarm_start);
					check_field("low_setpoint_out", want.low_sp, low_setpoint_out);
					check_field("high_setpoint_out", want.high_sp, high_setpoint_out);
					check_field("adjusting_high", want.adj_high, adjusting_high);
					check_field("encoder_count", want.count, encoder_count);
				end
			end
			if (in_valid && in_ready)
				status_q.push_back(next_status(opcode, enc_a, enc_b, low_pressed,
					high_pressed, raw_temperature));
			pending = status_q.size();
		end
	end

endmodule

/* tb/tb_thermostat_setpoint_controller.sv */
`timescale 1ns / 1ps

module tb_thermostat_setpoint_controller;
	import tsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL     = 60;
	localparam int SESSIONS       = 10;
	localparam int SESSION_ITEMS  = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            opcode;
	logic                  enc_a;
	logic                  enc_b;
	logic                  low_pressed;
	logic                  high_pressed;
	logic [10:0]           raw_temperature;
	logic                  out_valid;
	logic                  out_ready;
	logic [11:0]           fahrenheit_tenths;
	logic [5:0]            servo_position;
	logic [1:0]            led_color;
	logic                  alarm_start;
	logic [6:0]            low_setpoint_out;
	logic [6:0]            high_setpoint_out;
	logic                  adjusting_high;
	logic [6:0]            encoder_count;
	int                    mismatches;
	int                    pending;

	int         tx_idle_pct;
	int         rx_idle_pct;
	bit         stall_request;
	bit         stall_done;
	int         idle_cycles;
	logic [1:0] enc_phase;

	thermostat_setpoint_controller u_top (.*);
	thermostat_checker u_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// sink side: random back-pressure, plus one long hold-off when asked
	initial begin
		out_ready = 1'b0;
		stall_done = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request && !stall_done) begin
				stall_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("thermostat_setpoint_controller test failed");
					$finish;
				end
			end
		end
	end

	task automatic send_event(opcode_t op, logic a, logic b, logic lp, logic hp,
			logic [10:0] raw);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		enc_a <= a;
		enc_b <= b;
		low_pressed <= lp;
		high_pressed <= hp;
		raw_temperature <= raw;
		do @(posedge clk); while (!in_ready);
		// track the encoder phase so rotations stay well-formed
		if (op == OP_ENCODER && ({b, a} == quad_fwd(enc_phase) || {b, a} == quad_bwd(enc_phase)))
			enc_phase = {b, a};
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// unused upper data bits are randomized on the narrow registers
	task automatic apply_config(int mn, int mx, int mg, int fl, int cl);
		logic [CFG_DATA_W-1:0] d;
		write_reg(REG_SETPOINT_MIN, mn[6:0]);
		write_reg(REG_SETPOINT_MAX, mx[6:0]);
		d = $urandom;
		d[3:0] = mg[3:0];
		write_reg(REG_ALARM_MARGIN, d);
		d = $urandom;
		d[5:0] = fl[5:0];
		write_reg(REG_SERVO_FLOOR, d);
		d = $urandom;
		d[5:0] = cl[5:0];
		write_reg(REG_SERVO_CEILING, d);
	endtask

	// drain every outstanding transaction before touching the registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int s, items, n, r;
		bit up;
		logic [1:0] tgt;
		logic [10:0] raw;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ENCODER;
		enc_a = 1'b0;
		enc_b = 1'b0;
		low_pressed = 1'b0;
		high_pressed = 1'b0;
		raw_temperature = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SETPOINT_MIN;
		cfg_data = '0;
		tx_idle_pct = 22;
		rx_idle_pct = 72;
		stall_request = 1'b0;
		idle_cycles = 0;
		enc_phase = QUAD_PHASE_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// full up rotation from phase 3, one step down, then a skip and a repeat
		send_event(OP_ENCODER, 1'b0, 1'b1, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b0, 1'b0, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b1, 1'b0, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b1, 1'b1, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b1, 1'b0, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b0, 1'b1, $urandom, $urandom, $urandom);
		send_event(OP_ENCODER, 1'b1, 1'b0, $urandom, $urandom, $urandom);
		// cold fires the alarm, repeat stays latched, in range clears, hot fires
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd0);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd0);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd338);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd2047);
		send_event(OP_BUTTON, $urandom, $urandom, 1'b0, 1'b0, $urandom);
		send_event(OP_BUTTON, $urandom, $urandom, 1'b0, 1'b1, $urandom);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd1000);
		send_event(OP_BUTTON, $urandom, $urandom, 1'b1, 1'b0, $urandom);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd500);
		send_event(OP_BUTTON, $urandom, $urandom, 1'b1, 1'b1, $urandom);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd1500);
		send_event(OP_HOLD_DONE, $urandom, $urandom, $urandom, $urandom, $urandom);
		send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, 11'd1024);

		for (s = 0; s < SESSIONS; s++) begin
			if (s == 4) begin
				tx_idle_pct = 72;
				rx_idle_pct = 22;
			end
			if (s == 7) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			settle();
			case (s)
				0: apply_config(0, 127, 0, 0, 63);
				1: apply_config(127, 0, 15, 63, 0);
				2: apply_config(SETPOINT_MIN_RST, SETPOINT_MAX_RST, ALARM_MARGIN_RST,
					SERVO_FLOOR_RST, SERVO_CEILING_RST);
				default: apply_config($urandom_range(0, 80), $urandom_range(40, 127),
					$urandom_range(0, 15), $urandom_range(0, 40), $urandom_range(10, 63));
			endcase
			// sink holds off while the source keeps offering, so the pipe backs up
			if (s == 7)
				stall_request = 1'b1;
			items = 0;
			while (items < SESSION_ITEMS) begin
				r = $urandom_range(99);
				if (r < 50) begin
					up = $urandom_range(1);
					n = $urandom_range(1, 16);
					repeat (n) begin
						tgt = up ? quad_fwd(enc_phase) : quad_bwd(enc_phase);
						send_event(OP_ENCODER, tgt[0], tgt[1], $urandom, $urandom, $urandom);
					end
					items += n;
				end else begin
					raw = ($urandom_range(3) == 0) ? $urandom_range(0, 2047) :
						$urandom_range(0, 1000);
					if (r < 58)
						send_event(OP_ENCODER, $urandom, $urandom, $urandom, $urandom, raw);
					else if (r < 70)
						send_event(OP_BUTTON, $urandom, $urandom, $urandom, $urandom, raw);
					else if (r < 92)
						send_event(OP_TEMP, $urandom, $urandom, $urandom, $urandom, raw);
					else
						send_event(OP_HOLD_DONE, $urandom, $urandom, $urandom, $urandom, raw);
					items++;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (12) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("thermostat_setpoint_controller test passed");
		else
			$display("thermostat_setpoint_controller test failed");
		$finish;
	end

endmodule
